FILE: rtl/wsm_pkg.sv
`default_nettype none
package wsm_pkg;

    localparam int MAX_SLOTS = 16;
    localparam int IDX_W = $clog2(MAX_SLOTS);
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);
    localparam int CW = 19;

    typedef enum logic [1:0] {
        ST_CLOSED = 2'd0,
        ST_OPEN   = 2'd1,
        ST_MIN    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_DRAG   = 2'd1,
        ACT_RESIZE = 2'd2
    } t_act;

    typedef enum logic [3:0] {
        OP_ADD     = 4'd0,
        OP_FOCUS   = 4'd1,
        OP_MIN     = 4'd2,
        OP_RESTORE = 4'd3,
        OP_CLOSE   = 4'd4,
        OP_HIT     = 4'd5,
        OP_DRAG    = 4'd6,
        OP_RESIZE  = 4'd7,
        OP_MOVE    = 4'd8,
        OP_END     = 4'd9
    } t_op;

    localparam logic [2:0] CFG_SCREEN_W = 3'd0;
    localparam logic [2:0] CFG_SCREEN_H = 3'd1;
    localparam logic [2:0] CFG_PANEL_H  = 3'd2;
    localparam logic [2:0] CFG_MIN_W    = 3'd3;
    localparam logic [2:0] CFG_MIN_H    = 3'd4;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] w;
        logic signed [15:0] h;
    } t_box;

    typedef struct packed {
        t_status            status;
        logic [15:0]        ident;
        t_box               bounds;
        t_box               saved;
        logic [IDX_W-1:0]   order;
        logic [1:0]         flags;
    } t_slot;

    typedef struct packed {
        logic [3:0]         opcode;
        logic [15:0]        window_id;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] size_w;
        logic signed [15:0] size_h;
        logic               can_resize;
        logic               can_close;
    } t_in;

    typedef struct packed {
        logic        ok;
        logic [15:0] hit_id;
        logic [15:0] focused_id;
    } t_out;

endpackage
`default_nettype wire

FILE: rtl/window_stack_manager_top.sv
// window stack manager
// input: an item is taken at a clock edge with start high and busy low; the
// item is one opcode with its window id, point or bounds and flags
// result: o_done is high for exactly one cycle with o_result (ok, hit_id,
// focused_id); the receiver cannot stall, so the item must be taken then
// configuration: i_cfg_we with i_cfg_idx and i_cfg_data writes screen width,
// screen height, panel height, min width or min height at once
// timing: every item takes 2*MAX_SLOTS+6 busy cycles (38 at 16 slots), the
// result strobe is high in the first cycle with busy low and a new item may
// be taken in that same cycle, so one item every 39 cycles at most
// the cost is two passes over the slot table, one slot per cycle: a lookup
// pass (target, free slot, open count, hit test) and an update pass (order
// compaction, highest open window), plus four cycles of the shared clamp
// unit, one write cycle and one finishing cycle
// reset: all slots closed, no focus, no pointer action, screen registers
// back to 640 x 480, panel 28, minimum window 100 x 60
`default_nettype none
module window_stack_manager_top (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             start,
    output logic            busy,
    input  wsm_pkg::t_in    i_item,
    output logic            o_done,
    output wsm_pkg::t_out   o_result,
    input  wire             i_cfg_we,
    input  wire [2:0]       i_cfg_idx,
    input  wire [14:0]      i_cfg_data
);
    import wsm_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN1 = 6'b000010,
        S_CALC  = 6'b000100,
        S_APPLY = 6'b001000,
        S_SCAN2 = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    t_in    r_in, n_in;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [1:0] r_step, n_step;
    logic r_found, n_found;
    logic [IDX_W-1:0] r_t_idx, n_t_idx;
    t_slot r_t, n_t;
    logic r_free_found, n_free_found;
    logic [IDX_W-1:0] r_free_idx, n_free_idx;
    logic [CNT_W-1:0] r_act, n_act;
    logic r_hit_found, n_hit_found;
    logic [IDX_W-1:0] r_hit_ord, n_hit_ord;
    logic [15:0] r_hit_id, n_hit_id;
    t_box r_nb, n_nb;
    logic r_ok, n_ok, r_dec, n_dec, r_bring, n_bring, r_refocus, n_refocus;
    logic [IDX_W-1:0] r_old, n_old;
    logic r_hi_found, n_hi_found;
    logic [IDX_W-1:0] r_hi_ord, n_hi_ord;
    logic [15:0] r_hi_id, n_hi_id;
    logic [15:0] r_focus, n_focus;
    t_act r_mode, n_mode;
    logic [15:0] r_win, n_win;
    logic signed [15:0] r_spx, n_spx, r_spy, n_spy;
    t_box r_sb, n_sb;
    logic [14:0] r_scr_w, r_scr_h, r_panel, r_min_w, r_min_h;
    logic r_done, n_done;
    t_out r_res, n_res;

    t_slot rd, wr;
    logic wr_en, ord_we;
    logic [IDX_W-1:0] wr_idx, ord_idx, ord_val, new_ord;
    logic signed [CW-1:0] cv, clo, chi;
    logic signed [15:0] cres;
    logic signed [CW-1:0] c_sw, c_sh, c_ph, c_mw, c_mh, dx, dy;
    logic signed [16:0] xe, ye;
    logic [15:0] key;
    logic dec_hit, pt_in;

    wsm_slots u_slots (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_idx (r_idx),
        .o_rd     (rd),
        .i_wr_en  (wr_en),
        .i_wr_idx (wr_idx),
        .i_wr     (wr),
        .i_ord_we (ord_we),
        .i_ord_idx(ord_idx),
        .i_ord_val(ord_val)
    );

    wsm_calc u_calc (
        .i_v  (cv),
        .i_lo (clo),
        .i_hi (chi),
        .o_res(cres)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_w <= 15'd640;
            r_scr_h <= 15'd480;
            r_panel <= 15'd28;
            r_min_w <= 15'd100;
            r_min_h <= 15'd60;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SCREEN_W: r_scr_w <= i_cfg_data;
                CFG_SCREEN_H: r_scr_h <= i_cfg_data;
                CFG_PANEL_H:  r_panel <= i_cfg_data;
                CFG_MIN_W:    r_min_w <= i_cfg_data;
                CFG_MIN_H:    r_min_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        c_sw = CW'(r_scr_w);
        c_sh = CW'(r_scr_h);
        c_ph = CW'(r_panel);
        c_mw = CW'(r_min_w);
        c_mh = CW'(r_min_h);
        dx   = CW'(r_in.pos_x) - CW'(r_spx);
        dy   = CW'(r_in.pos_y) - CW'(r_spy);
        key  = (r_in.opcode == OP_MOVE) ? r_win : r_in.window_id;
        xe   = 17'(rd.bounds.x) + 17'(rd.bounds.w);
        ye   = 17'(rd.bounds.y) + 17'(rd.bounds.h);
        pt_in = (r_in.pos_x >= rd.bounds.x) && (17'(r_in.pos_x) < xe) &&
                (r_in.pos_y >= rd.bounds.y) && (17'(r_in.pos_y) < ye);
        dec_hit = r_dec && (rd.status != ST_CLOSED) && !(r_found && r_idx == r_t_idx) &&
                  (rd.order > r_old);
        new_ord = dec_hit ? rd.order - 1'b1 : rd.order;

        cv  = CW'(r_in.size_w);
        clo = c_mw;
        chi = c_sw;
        case (r_step)
            2'd0: begin
                if (r_in.opcode == OP_ADD) begin
                    cv = CW'(r_in.size_w); clo = c_mw; chi = c_sw;
                end else if (r_mode == ACT_DRAG) begin
                    cv = CW'(r_sb.x) + dx; clo = '0; chi = c_sw - CW'(r_sb.w);
                end else begin
                    cv = CW'(r_sb.w) + dx; clo = c_mw; chi = c_sw - CW'(r_sb.x);
                end
            end
            2'd1: begin
                if (r_in.opcode == OP_ADD) begin
                    cv = CW'(r_in.size_h); clo = c_mh; chi = c_sh - c_ph;
                end else if (r_mode == ACT_DRAG) begin
                    cv = CW'(r_sb.y) + dy; clo = c_ph; chi = c_sh - CW'(r_sb.h);
                end else begin
                    cv = CW'(r_sb.h) + dy; clo = c_mh; chi = c_sh - CW'(r_sb.y);
                end
            end
            2'd2: begin
                cv = CW'(r_in.pos_x); clo = '0; chi = c_sw - CW'(r_nb.w);
            end
            default: begin
                cv = CW'(r_in.pos_y); clo = c_ph; chi = c_sh - CW'(r_nb.h);
            end
        endcase
    end

    always_comb begin
        n_state = r_state;  n_in = r_in;  n_idx = r_idx;  n_step = r_step;
        n_found = r_found;  n_t_idx = r_t_idx;  n_t = r_t;
        n_free_found = r_free_found;  n_free_idx = r_free_idx;  n_act = r_act;
        n_hit_found = r_hit_found;  n_hit_ord = r_hit_ord;  n_hit_id = r_hit_id;
        n_nb = r_nb;  n_ok = r_ok;  n_dec = r_dec;  n_bring = r_bring;
        n_refocus = r_refocus;  n_old = r_old;
        n_hi_found = r_hi_found;  n_hi_ord = r_hi_ord;  n_hi_id = r_hi_id;
        n_focus = r_focus;  n_mode = r_mode;  n_win = r_win;
        n_spx = r_spx;  n_spy = r_spy;  n_sb = r_sb;
        n_done = 1'b0;  n_res = r_res;
        wr = r_t;  wr_idx = r_t_idx;  wr_en = 1'b0;
        ord_we = 1'b0;  ord_idx = r_idx;  ord_val = new_ord;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_in = i_item;
                    n_idx = '0;
                    n_step = '0;
                    n_found = 1'b0;
                    n_free_found = 1'b0;
                    n_act = '0;
                    n_hit_found = 1'b0;
                    n_hit_id = '0;
                    n_hi_found = 1'b0;
                    n_hi_id = '0;
                    n_state = S_SCAN1;
                end
            end
            S_SCAN1: begin
                if (rd.status != ST_CLOSED && key != '0 && rd.ident == key) begin
                    n_found = 1'b1;
                    n_t_idx = r_idx;
                    n_t = rd;
                end
                if (rd.status == ST_CLOSED) begin
                    if (!r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx = r_idx;
                    end
                end else begin
                    n_act = r_act + 1'b1;
                end
                if (rd.status == ST_OPEN && pt_in && (!r_hit_found || rd.order > r_hit_ord)) begin
                    n_hit_found = 1'b1;
                    n_hit_ord = rd.order;
                    n_hit_id = rd.ident;
                end
                n_idx = r_idx + 1'b1;
                if (r_idx == IDX_W'(MAX_SLOTS - 1)) begin
                    n_idx = '0;
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                case (r_step)
                    2'd0: begin
                        if (r_in.opcode == OP_ADD || r_mode == ACT_RESIZE) begin
                            n_nb.w = cres;
                        end else begin
                            n_nb.x = cres;
                        end
                    end
                    2'd1: begin
                        if (r_in.opcode == OP_ADD || r_mode == ACT_RESIZE) begin
                            n_nb.h = cres;
                        end else begin
                            n_nb.y = cres;
                        end
                    end
                    2'd2: begin
                        if (r_in.opcode == OP_ADD) begin
                            n_nb.x = cres;
                        end
                    end
                    default: begin
                        if (r_in.opcode == OP_ADD) begin
                            n_nb.y = cres;
                        end
                    end
                endcase
                n_step = r_step + 1'b1;
                if (r_step == 2'd3) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                n_ok = 1'b0;
                n_dec = 1'b0;
                n_bring = 1'b0;
                n_refocus = 1'b0;
                n_old = r_t.order;
                case (r_in.opcode)
                    OP_ADD: begin
                        if (r_in.window_id != '0 && !r_found && r_free_found) begin
                            wr_idx = r_free_idx;
                            wr.status = ST_OPEN;
                            wr.ident = r_in.window_id;
                            wr.bounds = r_nb;
                            wr.saved = r_nb;
                            wr.order = r_act[IDX_W-1:0];
                            wr.flags = {r_in.can_close, r_in.can_resize};
                            wr_en = 1'b1;
                            n_focus = r_in.window_id;
                            n_ok = 1'b1;
                        end
                    end
                    OP_FOCUS: begin
                        if (r_found && r_t.status == ST_OPEN) begin
                            n_focus = r_in.window_id;
                            n_dec = 1'b1;
                            n_bring = 1'b1;
                            n_ok = 1'b1;
                        end
                    end
                    OP_MIN: begin
                        if (r_found && r_t.status == ST_OPEN) begin
                            wr.saved = r_t.bounds;
                            wr.status = ST_MIN;
                            wr_en = 1'b1;
                            if (r_win == r_in.window_id) begin
                                n_mode = ACT_NONE;
                                n_win = '0;
                            end
                            n_refocus = (r_focus == r_in.window_id);
                            n_ok = 1'b1;
                        end
                    end
                    OP_RESTORE: begin
                        if (r_found && r_t.status == ST_MIN) begin
                            wr.bounds = r_t.saved;
                            wr.status = ST_OPEN;
                            wr_en = 1'b1;
                            n_focus = r_in.window_id;
                            n_dec = 1'b1;
                            n_bring = 1'b1;
                            n_ok = 1'b1;
                        end
                    end
                    OP_CLOSE: begin
                        if (r_found && r_t.flags[1]) begin
                            wr.status = ST_CLOSED;
                            wr.ident = '0;
                            wr_en = 1'b1;
                            if (r_win == r_in.window_id) begin
                                n_mode = ACT_NONE;
                                n_win = '0;
                            end
                            n_dec = 1'b1;
                            n_refocus = (r_focus == r_in.window_id);
                            n_ok = 1'b1;
                        end
                    end
                    OP_HIT: begin
                        n_ok = 1'b1;
                    end
                    OP_DRAG, OP_RESIZE: begin
                        if (r_found && r_t.status == ST_OPEN &&
                            (r_in.opcode == OP_DRAG || r_t.flags[0])) begin
                            n_focus = r_in.window_id;
                            n_dec = 1'b1;
                            n_bring = 1'b1;
                            n_mode = (r_in.opcode == OP_DRAG) ? ACT_DRAG : ACT_RESIZE;
                            n_win = r_in.window_id;
                            n_spx = r_in.pos_x;
                            n_spy = r_in.pos_y;
                            n_sb = r_t.bounds;
                            n_ok = 1'b1;
                        end
                    end
                    OP_MOVE: begin
                        n_ok = 1'b1;
                        if (!r_found || r_t.status != ST_OPEN) begin
                            n_mode = ACT_NONE;
                            n_win = '0;
                        end else if (r_mode == ACT_DRAG) begin
                            wr.bounds.x = r_nb.x;
                            wr.bounds.y = r_nb.y;
                            wr.bounds.w = r_sb.w;
                            wr.bounds.h = r_sb.h;
                            wr_en = 1'b1;
                        end else if (r_mode == ACT_RESIZE) begin
                            wr.bounds.w = r_nb.w;
                            wr.bounds.h = r_nb.h;
                            wr_en = 1'b1;
                        end
                    end
                    OP_END: begin
                        n_mode = ACT_NONE;
                        n_win = '0;
                        n_ok = 1'b1;
                    end
                    default: ;
                endcase
                n_state = S_SCAN2;
            end
            S_SCAN2: begin
                ord_we = dec_hit;
                if (rd.status == ST_OPEN && (!r_hi_found || new_ord > r_hi_ord)) begin
                    n_hi_found = 1'b1;
                    n_hi_ord = new_ord;
                    n_hi_id = rd.ident;
                end
                n_idx = r_idx + 1'b1;
                if (r_idx == IDX_W'(MAX_SLOTS - 1)) begin
                    n_idx = '0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                ord_we = r_bring;
                ord_idx = r_t_idx;
                ord_val = IDX_W'(r_act - 1'b1);
                if (r_refocus) begin
                    n_focus = r_hi_found ? r_hi_id : '0;
                end
                n_done = 1'b1;
                n_res.ok = r_ok;
                n_res.hit_id = (r_in.opcode == OP_HIT && r_hit_found) ? r_hit_id : '0;
                n_res.focused_id = n_focus;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_focus <= '0;
            r_mode <= ACT_NONE;
            r_win <= '0;
            r_spx <= '0;
            r_spy <= '0;
            r_sb <= '0;
            r_done <= 1'b0;
        end else begin
            r_state <= n_state;
            r_focus <= n_focus;
            r_mode <= n_mode;
            r_win <= n_win;
            r_spx <= n_spx;
            r_spy <= n_spy;
            r_sb <= n_sb;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= n_in;  r_idx <= n_idx;  r_step <= n_step;
        r_found <= n_found;  r_t_idx <= n_t_idx;  r_t <= n_t;
        r_free_found <= n_free_found;  r_free_idx <= n_free_idx;  r_act <= n_act;
        r_hit_found <= n_hit_found;  r_hit_ord <= n_hit_ord;  r_hit_id <= n_hit_id;
        r_nb <= n_nb;  r_ok <= n_ok;  r_dec <= n_dec;  r_bring <= n_bring;
        r_refocus <= n_refocus;  r_old <= n_old;
        r_hi_found <= n_hi_found;  r_hi_ord <= n_hi_ord;  r_hi_id <= n_hi_id;
        r_res <= n_res;
    end

    assign busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_result = r_res;

endmodule
`default_nettype wire

FILE: rtl/wsm_slots.sv
`default_nettype none
module wsm_slots (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire [wsm_pkg::IDX_W-1:0]  i_rd_idx,
    output wsm_pkg::t_slot            o_rd,
    input  wire                       i_wr_en,
    input  wire [wsm_pkg::IDX_W-1:0]  i_wr_idx,
    input  wsm_pkg::t_slot            i_wr,
    input  wire                       i_ord_we,
    input  wire [wsm_pkg::IDX_W-1:0]  i_ord_idx,
    input  wire [wsm_pkg::IDX_W-1:0]  i_ord_val
);
    import wsm_pkg::*;

    t_status r_status [MAX_SLOTS];
    t_slot   r_ent    [MAX_SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_SLOTS; i++) begin
                r_status[i] <= ST_CLOSED;
            end
        end else if (i_wr_en) begin
            r_status[i_wr_idx] <= i_wr.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_ent[i_wr_idx] <= i_wr;
        end
        if (i_ord_we) begin
            r_ent[i_ord_idx].order <= i_ord_val;
        end
    end

    always_comb begin
        o_rd        = r_ent[i_rd_idx];
        o_rd.status = r_status[i_rd_idx];
    end

endmodule
`default_nettype wire

FILE: rtl/wsm_calc.sv
`default_nettype none
module wsm_calc (
    input  wire signed [wsm_pkg::CW-1:0] i_v,
    input  wire signed [wsm_pkg::CW-1:0] i_lo,
    input  wire signed [wsm_pkg::CW-1:0] i_hi,
    output logic signed [15:0]           o_res
);
    import wsm_pkg::*;

    logic signed [CW-1:0] c;

    always_comb begin
        if (i_v < i_lo) begin
            c = i_lo;
        end else if (i_v > i_hi) begin
            c = i_hi;
        end else begin
            c = i_v;
        end
        if (c < -CW'(32768)) begin
            o_res = 16'sh8000;
        end else if (c > CW'(32767)) begin
            o_res = 16'sh7fff;
        end else begin
            o_res = c[15:0];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/wsm_checker.sv
`default_nettype none
module wsm_checker (
    input wire           i_clk,
    input wire           i_rst_n,
    input wire           start,
    input wire           busy,
    input wire           o_done,
    input wsm_pkg::t_out o_result
);
    import wsm_pkg::*;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while busy");

    a_fall_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("item finished without a result");

    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_hit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.hit_id != 16'd0 |-> o_result.ok)
        else $error("hit id without ok");

endmodule

bind window_stack_manager_top wsm_checker u_wsm_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_result(o_result)
);
`default_nettype wire

FILE: bench/testbench.sv
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import wsm_pkg::*;

    typedef struct {
        t_status     status;
        logic [15:0] ident;
        t_box        bounds;
        t_box        saved;
        int          order;
        logic [1:0]  flags;
    } t_win;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_in         i_item = '0;
    logic        o_done;
    t_out        o_result;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [14:0] i_cfg_data = '0;

    window_stack_manager_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_done(o_done), .o_result(o_result),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_win        wins[MAX_SLOTS];
    logic [15:0] focus_id;
    t_act        act_mode;
    logic [15:0] act_win;
    int          act_px, act_py;
    t_box        act_box;
    int          scr_w, scr_h, panel_h, min_w, min_h;

    t_in  pending_items[$];
    t_out expected_results[$];
    int   failures = 0;
    int   cycles = 0;
    int   gap = 0;
    logic [15:0] used_ids[$];

    function automatic int clampv(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [15:0] sat16(int v);
        if (v < -32768) return 16'h8000;
        if (v > 32767) return 16'h7fff;
        return v[15:0];
    endfunction

    function automatic int find_win(logic [15:0] id);
        if (id == 0) return -1;
        for (int i = 0; i < MAX_SLOTS; i++)
            if (wins[i].status != ST_CLOSED && wins[i].ident == id) return i;
        return -1;
    endfunction

    function automatic void raise_win(int t);
        int old;
        int cnt;
        old = wins[t].order;
        cnt = 0;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            if (i == t || wins[i].status == ST_CLOSED) continue;
            cnt++;
            if (wins[i].order > old) wins[i].order--;
        end
        wins[t].order = cnt;
    endfunction

    function automatic logic [15:0] top_open();
        int best;
        best = -1;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            if (wins[i].status != ST_OPEN) continue;
            if (best < 0 || wins[i].order > wins[best].order) best = i;
        end
        return best < 0 ? 16'd0 : wins[best].ident;
    endfunction

    function automatic void reset_windows();
        for (int i = 0; i < MAX_SLOTS; i++) begin
            wins[i].status = ST_CLOSED;
            wins[i].ident = 0;
            wins[i].bounds = '0;
            wins[i].saved = '0;
            wins[i].order = 0;
            wins[i].flags = 0;
        end
        focus_id = 0;
        act_mode = ACT_NONE;
        act_win = 0;
        act_px = 0;
        act_py = 0;
        act_box = '0;
        scr_w = 640; scr_h = 480; panel_h = 28; min_w = 100; min_h = 60;
    endfunction

    function automatic t_out predict_window_op(t_in it);
        t_out r;
        int s, slot, active, old, dx, dy, best;
        int px, py;
        t_box b;
        r = '0;
        px = it.pos_x;
        py = it.pos_y;
        s = find_win(it.window_id);
        case (it.opcode)
            OP_ADD: begin
                slot = -1;
                active = 0;
                if (it.window_id != 0 && s < 0) begin
                    for (int i = 0; i < MAX_SLOTS; i++)
                        if (wins[i].status == ST_CLOSED) begin
                            if (slot < 0) slot = i;
                        end else active++;
                    if (slot >= 0) begin
                        b.w = sat16(clampv(it.size_w, min_w, scr_w));
                        b.h = sat16(clampv(it.size_h, min_h, scr_h - panel_h));
                        b.x = sat16(clampv(px, 0, scr_w - b.w));
                        b.y = sat16(clampv(py, panel_h, scr_h - b.h));
                        wins[slot].ident = it.window_id;
                        wins[slot].bounds = b;
                        wins[slot].saved = b;
                        wins[slot].status = ST_OPEN;
                        wins[slot].order = active;
                        wins[slot].flags = {it.can_close, it.can_resize};
                        focus_id = it.window_id;
                        raise_win(slot);
                        r.ok = 1'b1;
                    end
                end
            end
            OP_FOCUS: begin
                if (s >= 0 && wins[s].status == ST_OPEN) begin
                    focus_id = it.window_id;
                    raise_win(s);
                    r.ok = 1'b1;
                end
            end
            OP_MIN: begin
                if (s >= 0 && wins[s].status == ST_OPEN) begin
                    wins[s].saved = wins[s].bounds;
                    wins[s].status = ST_MIN;
                    if (act_win == it.window_id) begin
                        act_mode = ACT_NONE;
                        act_win = 0;
                    end
                    if (focus_id == it.window_id) focus_id = top_open();
                    r.ok = 1'b1;
                end
            end
            OP_RESTORE: begin
                if (s >= 0 && wins[s].status == ST_MIN) begin
                    wins[s].bounds = wins[s].saved;
                    wins[s].status = ST_OPEN;
                    focus_id = it.window_id;
                    raise_win(s);
                    r.ok = 1'b1;
                end
            end
            OP_CLOSE: begin
                if (s >= 0 && wins[s].flags[1]) begin
                    old = wins[s].order;
                    wins[s].status = ST_CLOSED;
                    wins[s].ident = 0;
                    if (act_win == it.window_id) begin
                        act_mode = ACT_NONE;
                        act_win = 0;
                    end
                    for (int i = 0; i < MAX_SLOTS; i++)
                        if (wins[i].status != ST_CLOSED && wins[i].order > old)
                            wins[i].order--;
                    if (focus_id == it.window_id) focus_id = top_open();
                    r.ok = 1'b1;
                end
            end
            OP_HIT: begin
                best = -1;
                for (int i = 0; i < MAX_SLOTS; i++) begin
                    b = wins[i].bounds;
                    if (wins[i].status != ST_OPEN) continue;
                    if (px < b.x || px >= int'(b.x) + int'(b.w) ||
                        py < b.y || py >= int'(b.y) + int'(b.h)) continue;
                    if (best < 0 || wins[i].order > wins[best].order) best = i;
                end
                r.hit_id = best < 0 ? 16'd0 : wins[best].ident;
                r.ok = 1'b1;
            end
            OP_DRAG, OP_RESIZE: begin
                if (s >= 0 && wins[s].status == ST_OPEN &&
                    !(it.opcode == OP_RESIZE && !wins[s].flags[0])) begin
                    focus_id = it.window_id;
                    raise_win(s);
                    act_mode = (it.opcode == OP_DRAG) ? ACT_DRAG : ACT_RESIZE;
                    act_win = it.window_id;
                    act_px = px;
                    act_py = py;
                    act_box = wins[s].bounds;
                    r.ok = 1'b1;
                end
            end
            OP_MOVE: begin
                r.ok = 1'b1;
                dx = px - act_px;
                dy = py - act_py;
                s = find_win(act_win);
                if (s < 0 || wins[s].status != ST_OPEN) begin
                    act_mode = ACT_NONE;
                    act_win = 0;
                end else if (act_mode == ACT_DRAG) begin
                    b = act_box;
                    b.x = sat16(clampv(act_box.x + dx, 0, scr_w - act_box.w));
                    b.y = sat16(clampv(act_box.y + dy, panel_h, scr_h - act_box.h));
                    wins[s].bounds = b;
                end else if (act_mode == ACT_RESIZE) begin
                    wins[s].bounds.w = sat16(clampv(act_box.w + dx, min_w,
                                                    scr_w - act_box.x));
                    wins[s].bounds.h = sat16(clampv(act_box.h + dy, min_h,
                                                    scr_h - act_box.y));
                end
            end
            OP_END: begin
                act_mode = ACT_NONE;
                act_win = 0;
                r.ok = 1'b1;
            end
            default: ;
        endcase
        r.focused_id = focus_id;
        return r;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                start <= 1'b0;
                gap = $urandom_range(0, 6);
            end else if (!start) begin
                if (gap > 0) gap--;
                else if (pending_items.size() > 0) begin
                    i_item <= pending_items.pop_front();
                    start <= 1'b1;
                end
            end
        end
    end

    // predict on acceptance, check on strobe
    always @(posedge i_clk) begin
        cycles++;
        if (i_rst_n && start && !busy)
            expected_results.push_back(predict_window_op(i_item));
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                $display("%0t unexpected result %p", $time, o_result);
                failures++;
            end else begin
                t_out e;
                e = expected_results.pop_front();
                if (e.ok !== o_result.ok) begin
                    $display("%0t ok: expected %0d actual %0d", $time, e.ok, o_result.ok);
                    failures++;
                end
                if (e.hit_id !== o_result.hit_id) begin
                    $display("%0t hit_id: expected %0d actual %0d", $time, e.hit_id,
                             o_result.hit_id);
                    failures++;
                end
                if (e.focused_id !== o_result.focused_id) begin
                    $display("%0t focused_id: expected %0d actual %0d", $time,
                             e.focused_id, o_result.focused_id);
                    failures++;
                end
            end
        end
        if (cycles > 400000) begin
            $display("[window_stack_manager_top] ERROR");
            $finish;
        end
    end

    function automatic logic [15:0] pick_id();
        if (used_ids.size() > 0 && $urandom_range(0, 9) < 8)
            return used_ids[$urandom_range(0, used_ids.size() - 1)];
        if ($urandom_range(0, 19) == 0) return 16'd0;
        return 16'($urandom_range(1, 65535));
    endfunction

    function automatic t_in make_item(t_op op, logic [15:0] id, int x, int y, int w,
                                      int h, logic rz, logic cl);
        t_in it;
        it.opcode = op;
        it.window_id = id;
        it.pos_x = x[15:0];
        it.pos_y = y[15:0];
        it.size_w = w[15:0];
        it.size_h = h[15:0];
        it.can_resize = rz;
        it.can_close = cl;
        return it;
    endfunction

    function automatic int rnd_coord();
        case ($urandom_range(0, 3))
            0: return int'($signed(16'($urandom)));
            default: return $urandom_range(0, 700) - 50;
        endcase
    endfunction

    function automatic t_in random_item();
        t_in it;
        int r;
        logic [15:0] id;
        r = $urandom_range(0, 99);
        id = pick_id();
        if (r < 20) begin
            if ($urandom_range(0, 1)) id = 16'($urandom_range(1, 65535));
            it = make_item(OP_ADD, id, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                           $urandom_range(0, 1), $urandom_range(0, 3) != 0);
            if (id != 0) used_ids.push_back(id);
            if (used_ids.size() > 40) void'(used_ids.pop_front());
        end else if (r < 97) begin
            it = make_item(t_op'($urandom_range(1, 9)), id, rnd_coord(), rnd_coord(),
                           rnd_coord(), rnd_coord(), $urandom_range(0, 1),
                           $urandom_range(0, 1));
        end else begin
            it = t_in'({$urandom, $urandom});
            it.opcode = 4'($urandom_range(10, 15));
        end
        return it;
    endfunction

    task automatic write_cfg(logic [2:0] idx, int v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v[14:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SCREEN_W: scr_w = v;
            CFG_SCREEN_H: scr_h = v;
            CFG_PANEL_H: panel_h = v;
            CFG_MIN_W: min_w = v;
            CFG_MIN_H: min_h = v;
            default: ;
        endcase
    endtask

    task automatic drain();
        wait (pending_items.size() == 0 && !start);
        @(posedge i_clk);
        wait (expected_results.size() == 0);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic run_random(int n);
        for (int k = 0; k < n; k++) pending_items.push_back(random_item());
        drain();
    endtask

    initial begin
        reset_windows();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // directed
        pending_items.push_back(make_item(OP_ADD, 16'd0, 0, 0, 10, 10, 1, 1));
        pending_items.push_back(make_item(OP_ADD, 16'hffff, -32768, -32768, -32768,
                                          -32768, 1, 1));
        pending_items.push_back(make_item(OP_ADD, 16'd1, 32767, 32767, 32767, 32767,
                                          0, 0));
        pending_items.push_back(make_item(OP_ADD, 16'd1, 5, 5, 200, 200, 1, 1));
        pending_items.push_back(make_item(OP_ADD, 16'd2, 100, 100, 300, 200, 1, 1));
        pending_items.push_back(make_item(OP_HIT, 16'd0, 150, 150, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_HIT, 16'd0, 399, 299, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_HIT, 16'd0, 400, 300, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_FOCUS, 16'hffff, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_DRAG, 16'd2, 10, 10, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_MOVE, 16'd0, 32767, -32768, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_RESIZE, 16'd1, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_RESIZE, 16'd2, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_MOVE, 16'd0, -32768, 32767, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_MIN, 16'd2, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_MOVE, 16'd0, 5, 5, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_RESTORE, 16'd2, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_CLOSE, 16'd1, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_CLOSE, 16'hffff, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_END, 16'd0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(t_op'(4'd15), 16'd2, 0, 0, 0, 0, 1, 1));
        for (int k = 0; k < 17; k++)
            pending_items.push_back(make_item(OP_ADD, 16'(100 + k), k * 20, k * 20,
                                              150, 100, 1, 1));
        drain();
        run_random(300);
        write_cfg(CFG_SCREEN_W, 32767);
        write_cfg(CFG_SCREEN_H, 32767);
        write_cfg(CFG_PANEL_H, 0);
        write_cfg(CFG_MIN_W, 1);
        write_cfg(CFG_MIN_H, 1);
        run_random(250);
        write_cfg(CFG_SCREEN_W, 1);
        write_cfg(CFG_SCREEN_H, 1);
        write_cfg(CFG_PANEL_H, 32767);
        write_cfg(CFG_MIN_W, 32767);
        write_cfg(CFG_MIN_H, 32767);
        run_random(150);
        write_cfg(CFG_SCREEN_W, 800);
        write_cfg(CFG_SCREEN_H, 600);
        write_cfg(CFG_PANEL_H, 20);
        write_cfg(CFG_MIN_W, 50);
        write_cfg(CFG_MIN_H, 40);
        run_random(300);
        if (failures == 0) begin
            $display("[window_stack_manager_top] OK");
        end else begin
            $display("[window_stack_manager_top] ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: files.f
rtl/wsm_pkg.sv
rtl/wsm_slots.sv
rtl/wsm_calc.sv
rtl/window_stack_manager_top.sv
rtl/wsm_checker.sv
bench/testbench.sv
